>>> rtl/core/lcache_pkg.sv
// ----------------------------------------------------------------------------
// LRU cache table package
// Shared types and constants for the fully associative LRU key/value table.
// ----------------------------------------------------------------------------
package lcache_pkg;

	localparam int VALUE_BITS = 32;
	localparam int IN_KEY_BITS = 16;
	localparam int CAP_BITS = 5;
	localparam int IN_TDATA_BITS = 56;
	localparam int OUT_TDATA_BITS = 72;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOKUP = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_stall;
	} ctrl_sts_t;

endpackage

>>> rtl/core/lcache_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcache_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/lcache_ctrl.sv
// ----------------------------------------------------------------------------
// LRU cache table controller
// Sequences each item through accept, lookup and update.
// ----------------------------------------------------------------------------
module lcache_ctrl
	import lcache_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (!sts.out_stall) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/lcache_dp.sv
// ----------------------------------------------------------------------------
// LRU cache table datapath
// Key match array, recency ranks, value RAM and the result register.
// ----------------------------------------------------------------------------
module lcache_dp
	import lcache_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctrl_cmd_t                    cmd,
	output ctrl_sts_t                    sts,
	input  logic                         cfg_wr_en,
	input  logic [CAP_BITS-1:0]          cfg_wr_data,
	input  logic                         in_opcode,
	input  logic [IN_KEY_BITS-1:0]       in_key,
	input  logic signed [VALUE_BITS-1:0] in_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_hit,
	output logic signed [VALUE_BITS-1:0] out_read_value,
	output logic                         out_recent_valid,
	output logic signed [VALUE_BITS-1:0] out_recent_value,
	output logic                         out_evicted
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_BITS) ? CW : CAP_BITS;

	logic [CAP_BITS-1:0]          cap_q;
	logic                         op_q;
	logic [KEY_BITS-1:0]          key_q;
	logic signed [VALUE_BITS-1:0] wval_q;

	logic [KEY_BITS-1:0] key_tab_q [DEPTH];
	logic [AW-1:0]       rank_q [DEPTH];
	logic [DEPTH-1:0]    valid_q;
	logic [CW-1:0]       count_q;

	logic                         hit_s1;
	logic [DEPTH-1:0]             hit_oh_s1;
	logic [AW-1:0]                hit_rank_s1;
	logic                         evict_s1;
	logic [DEPTH-1:0]             victim_oh_s1;
	logic [DEPTH-1:0]             slot_oh_s1;
	logic [AW-1:0]                wr_idx_s1;

	logic signed [VALUE_BITS-1:0] recent_value_q;
	logic                         out_valid_q;
	logic                         out_hit_q;
	logic signed [VALUE_BITS-1:0] out_read_value_q;
	logic                         out_recent_valid_q;
	logic signed [VALUE_BITS-1:0] out_recent_value_q;
	logic                         out_evicted_q;

	logic [KEY_BITS+IN_KEY_BITS-1:0] key_ext;
	logic [DEPTH-1:0]                match;
	logic [AW-1:0]                   hit_idx;
	logic [AW-1:0]                   hit_rank;
	logic [DEPTH-1:0]                victim_oh;
	logic [DEPTH-1:0]                free_vec;
	logic [DEPTH-1:0]                slot_oh;
	logic [AW-1:0]                   slot_idx;
	logic [EW-1:0]                   cap_ext;
	logic [EW-1:0]                   eff_cap;
	logic                            full;
	logic                            evict;
	logic [CW-1:0]                   last_rank;
	logic signed [VALUE_BITS-1:0]    ram_rdata;
	logic                            ram_we;
	logic                            put_miss;

	assign key_ext = {{KEY_BITS{1'b0}}, in_key};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_opcode;
			key_q <= key_ext[KEY_BITS-1:0];
			wval_q <= in_value;
		end
	end

	assign last_rank = count_q - CW'(1);
	assign cap_ext = EW'(cap_q);

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(DEPTH)) begin
			eff_cap = EW'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full = EW'(count_q) >= eff_cap;
	assign evict = (op_q == OP_PUT) && (match == '0) && full;

	always_comb begin
		hit_idx = '0;
		hit_rank = '0;
		victim_oh = '0;
		for (int j = 0; j < DEPTH; j++) begin
			match[j] = valid_q[j] && (key_tab_q[j] == key_q);
			if (match[j]) begin
				hit_idx = hit_idx | AW'(j);
				hit_rank = hit_rank | rank_q[j];
			end
			victim_oh[j] = valid_q[j] && (CW'(rank_q[j]) == last_rank);
		end
	end

	assign free_vec = ~valid_q | (evict ? victim_oh : '0);
	assign slot_oh = free_vec & (~free_vec + DEPTH'(1));

	always_comb begin
		slot_idx = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if (slot_oh[j]) begin
				slot_idx = slot_idx | AW'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s1 <= (match != '0);
			hit_oh_s1 <= match;
			hit_rank_s1 <= hit_rank;
			evict_s1 <= evict;
			victim_oh_s1 <= victim_oh;
			slot_oh_s1 <= slot_oh;
			wr_idx_s1 <= (match != '0) ? hit_idx : slot_idx;
		end
	end

	assign put_miss = (op_q == OP_PUT) && !hit_s1;
	assign ram_we = cmd.commit && (op_q == OP_PUT);

	lcache_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_value_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_s1),
		.wdata(wval_q),
		.raddr(hit_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		for (int j = 0; j < DEPTH; j++) begin
			if (cmd.commit && put_miss && slot_oh_s1[j]) begin
				key_tab_q[j] <= key_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			recent_value_q <= '0;
			for (int j = 0; j < DEPTH; j++) begin
				rank_q[j] <= '0;
			end
		end else if (cmd.commit) begin
			if (hit_s1) begin
				for (int j = 0; j < DEPTH; j++) begin
					if (hit_oh_s1[j]) begin
						rank_q[j] <= '0;
					end else if (valid_q[j] && (rank_q[j] < hit_rank_s1)) begin
						rank_q[j] <= rank_q[j] + AW'(1);
					end
				end
				recent_value_q <= (op_q == OP_PUT) ? wval_q : ram_rdata;
			end else if (op_q == OP_PUT) begin
				for (int j = 0; j < DEPTH; j++) begin
					if (slot_oh_s1[j]) begin
						valid_q[j] <= 1'b1;
						rank_q[j] <= '0;
					end else if (evict_s1 && victim_oh_s1[j]) begin
						valid_q[j] <= 1'b0;
					end else if (valid_q[j]) begin
						rank_q[j] <= rank_q[j] + AW'(1);
					end
				end
				if (!evict_s1) begin
					count_q <= count_q + CW'(1);
				end
				recent_value_q <= wval_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit_q <= hit_s1;
			out_read_value_q <= (hit_s1 && (op_q == OP_GET)) ? ram_rdata : '0;
			out_evicted_q <= put_miss && evict_s1;
			if (hit_s1) begin
				out_recent_valid_q <= 1'b1;
				out_recent_value_q <= (op_q == OP_PUT) ? wval_q : ram_rdata;
			end else if (op_q == OP_PUT) begin
				out_recent_valid_q <= 1'b1;
				out_recent_value_q <= wval_q;
			end else begin
				out_recent_valid_q <= (count_q != '0);
				out_recent_value_q <= recent_value_q;
			end
		end
	end

	assign sts.out_stall = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_hit = out_hit_q;
	assign out_read_value = out_read_value_q;
	assign out_recent_valid = out_recent_valid_q;
	assign out_recent_value = out_recent_value_q;
	assign out_evicted = out_evicted_q;

endmodule

>>> rtl/core/lru_cache_table_unit.sv
// ----------------------------------------------------------------------------
// LRU cache table unit
// An input transfer is accepted in the idle state; the item then passes
// through the lookup and update states, and its result is registered as the
// update commits. No new item is accepted until this one is back in idle.
// A result waiting on the output does not block the next input transfer, but
// that item then holds in the update cycle until the waiting result is taken.
// Reset empties the table (valid bits, ranks, count) and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_cache_table_unit
	import lcache_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int KEY_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CAP_BITS-1:0]       cfg_wr_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// opcode[0], lookup_key[16:1], write_value[48:17], zero fill
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// hit[0], read_value[32:1], recent_valid[33], recent_value[65:34],
	// evicted[66], zero fill
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

	ctrl_cmd_t                    cmd;
	ctrl_sts_t                    sts;
	logic                         out_hit;
	logic signed [VALUE_BITS-1:0] out_read_value;
	logic                         out_recent_valid;
	logic signed [VALUE_BITS-1:0] out_recent_value;
	logic                         out_evicted;

	lcache_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lcache_dp #(
		.DEPTH   (DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_opcode       (s_axis_tdata[0]),
		.in_key          (s_axis_tdata[16:1]),
		.in_value        (s_axis_tdata[48:17]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_hit         (out_hit),
		.out_read_value  (out_read_value),
		.out_recent_valid(out_recent_valid),
		.out_recent_value(out_recent_value),
		.out_evicted     (out_evicted)
	);

	assign m_axis_tdata = {5'b0, out_evicted, out_recent_value, out_recent_valid,
		out_read_value, out_hit};

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted during lookup");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[66] |-> !m_axis_tdata[0] && m_axis_tdata[33])
		else $error("eviction reported with hit or empty table");

	a_empty_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[33] |-> m_axis_tdata[65:34] == '0)
		else $error("recent value nonzero on empty table");

	a_read_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[32:1] != '0) |-> m_axis_tdata[0])
		else $error("read value nonzero without hit");

endmodule
